@@ hw/rtl/sab_pkg.sv @@
// Shared types and constants for the suffix array builder.
package sab_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = 6;
    localparam int CW    = 7;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_text;
    } sab_in_t;

    typedef struct packed {
        logic [5:0] suffix_start;
        logic       final_entry;
    } sab_out_t;

endpackage

@@ hw/rtl/suffix_array_builder_core.sv @@
// Suffix array builder by prefix doubling over on-chip rank and next-rank memories.
//
// Usage: bytes of a string arrive on the s_ channel, one per beat, until a beat
// with end_of_text set or until MAX_LEN bytes are held. The block then sorts
// all suffixes and returns their start positions in sorted order on the m_
// channel, one beat per position, with final_entry set on the last one.
// s_ready is high only while loading; no byte is taken during a build or
// while results are being returned.
// A string of n bytes (n >= 2) is sorted in R = ceil(log2 n) rounds:
//   each round reads from the rank memory the key of a suffix and then
//   the key of every compared suffix, counting the smaller keys to form
//   its new rank in the next-rank memory, then copies the new ranks back;
//   the sorted order is then written into the next-rank memory, and every
//   result is read from it and held until the receiver takes it.
// A one-byte string skips the rounds and returns position 0 at once.
// When the receiver stalls, the result register holds its beat until taken.
// Reset (aresetn low, synchronous) returns the block to loading with an
// empty string; memory contents are not cleared.
module suffix_array_builder_core
    import sab_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sab_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sab_out_t m_data
);

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_PRD  = 4'd1;
    localparam logic [3:0] S_PCAP = 4'd2;
    localparam logic [3:0] S_QRD  = 4'd3;
    localparam logic [3:0] S_QCMP = 4'd4;
    localparam logic [3:0] S_CRD  = 4'd5;
    localparam logic [3:0] S_CWR  = 4'd6;
    localparam logic [3:0] S_ORD  = 4'd7;
    localparam logic [3:0] S_OWR  = 4'd8;
    localparam logic [3:0] S_ERD  = 4'd9;
    localparam logic [3:0] S_ELD  = 4'd10;
    localparam logic [3:0] S_EOUT = 4'd11;

    localparam logic [CW-1:0] LEN_LIMIT = CW'(MAX_LEN);

    logic [7:0]    rank_mem  [DEPTH];
    // next ranks during the rounds, then the sorted order for the results
    logic [CW-1:0] nrank_mem [DEPTH];

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] span_reg, span_next;
    logic [CW-1:0] p_reg, p_next;
    logic [CW-1:0] q_reg, q_next;
    logic [CW-1:0] lt_reg, lt_next;
    logic [16:0]   keyp_reg, keyp_next;
    logic          pv_reg;
    logic          m_valid_reg, m_valid_next;
    sab_out_t      m_data_reg, m_data_next;

    logic [7:0]    rd_a, rd_b;
    logic [CW-1:0] nr_rd;
    logic [AW-1:0] ord_rd;
    logic [AW-1:0] addr_a, addr_b;
    logic [CW-1:0] base, partner;
    logic          pv_next;
    logic          rank_we, order_we, nrank_we;
    logic [AW-1:0] rank_wa, order_wa, nrank_wa;
    logic [7:0]    rank_wd;
    logic [AW-1:0] order_wd;
    logic [CW-1:0] nrank_wd;
    logic [16:0]   key_cur;
    logic [CW-1:0] lt_sum;
    logic [CW-1:0] span_dbl;

    assign base    = (state_reg == S_QRD) ? q_reg : p_reg;
    assign partner = base + span_reg;
    assign pv_next = (partner < n_reg);
    assign addr_a  = base[AW-1:0];
    assign addr_b  = partner[AW-1:0];
    assign key_cur = {rd_a, pv_reg ? (9'(rd_b) + 9'd1) : 9'd0};
    assign lt_sum  = lt_reg + ((key_cur < keyp_reg) ? CW'(1) : CW'(0));
    assign span_dbl = {span_reg[CW-2:0], 1'b0};
    assign ord_rd  = nr_rd[AW-1:0];

    always_ff @(posedge aclk) begin
        rd_a   <= rank_mem[addr_a];
        rd_b   <= rank_mem[addr_b];
        nr_rd  <= nrank_mem[p_reg[AW-1:0]];
        pv_reg <= pv_next;
        if (rank_we) begin
            rank_mem[rank_wa] <= rank_wd;
        end
        if (nrank_we) begin
            nrank_mem[nrank_wa] <= nrank_wd;
        end else if (order_we) begin
            nrank_mem[order_wa] <= {1'b0, order_wd};
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        span_next    = span_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        lt_next      = lt_reg;
        keyp_next    = keyp_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        rank_we      = 1'b0;
        rank_wa      = cnt_reg[AW-1:0];
        rank_wd      = s_data.symbol;
        nrank_we     = 1'b0;
        nrank_wa     = p_reg[AW-1:0];
        nrank_wd     = lt_sum;
        order_we     = 1'b0;
        order_wa     = rd_a[AW-1:0];
        order_wd     = p_reg[AW-1:0];
        s_ready      = (state_reg == S_LOAD);
        case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    rank_we  = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                    if (s_data.end_of_text || (cnt_reg + CW'(1) >= LEN_LIMIT)) begin
                        n_next    = cnt_reg + CW'(1);
                        span_next = CW'(1);
                        p_next    = '0;
                        if (cnt_reg == '0) begin
                            // single byte: its only suffix is position zero
                            order_we   = 1'b1;
                            order_wa   = '0;
                            order_wd   = '0;
                            state_next = S_ERD;
                        end else begin
                            state_next = S_PRD;
                        end
                    end
                end
            end
            S_PRD: begin
                state_next = S_PCAP;
            end
            S_PCAP: begin
                keyp_next  = key_cur;
                q_next     = '0;
                lt_next    = '0;
                state_next = S_QRD;
            end
            S_QRD: begin
                state_next = S_QCMP;
            end
            S_QCMP: begin
                lt_next = lt_sum;
                q_next  = q_reg + CW'(1);
                if (q_reg + CW'(1) == n_reg) begin
                    nrank_we = 1'b1;
                    if (p_reg + CW'(1) == n_reg) begin
                        p_next     = '0;
                        state_next = S_CRD;
                    end else begin
                        p_next     = p_reg + CW'(1);
                        state_next = S_PRD;
                    end
                end else begin
                    state_next = S_QRD;
                end
            end
            S_CRD: begin
                state_next = S_CWR;
            end
            S_CWR: begin
                rank_we = 1'b1;
                rank_wa = p_reg[AW-1:0];
                rank_wd = {1'b0, nr_rd};
                if (p_reg + CW'(1) == n_reg) begin
                    span_next  = span_dbl;
                    p_next     = '0;
                    state_next = (span_dbl < n_reg) ? S_PRD : S_ORD;
                end else begin
                    p_next     = p_reg + CW'(1);
                    state_next = S_CRD;
                end
            end
            S_ORD: begin
                state_next = S_OWR;
            end
            S_OWR: begin
                // ranks are now distinct and dense: scatter positions by rank
                order_we = 1'b1;
                if (p_reg + CW'(1) == n_reg) begin
                    p_next     = '0;
                    state_next = S_ERD;
                end else begin
                    p_next     = p_reg + CW'(1);
                    state_next = S_ORD;
                end
            end
            S_ERD: begin
                state_next = S_ELD;
            end
            S_ELD: begin
                m_data_next.suffix_start = ord_rd;
                m_data_next.final_entry  = (p_reg + CW'(1) == n_reg);
                m_valid_next             = 1'b1;
                state_next               = S_EOUT;
            end
            S_EOUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (p_reg + CW'(1) == n_reg) begin
                        cnt_next   = '0;
                        span_next  = CW'(1);
                        state_next = S_LOAD;
                    end else begin
                        p_next     = p_reg + CW'(1);
                        state_next = S_ERD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            cnt_reg     <= '0;
            span_reg    <= CW'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            span_reg    <= span_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg      <= n_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        lt_reg     <= lt_next;
        keyp_reg   <= keyp_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_final_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.final_entry) |-> (p_reg + CW'(1) == n_reg))
        else $error("final flag away from the last position");

    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.final_entry) |=> (s_ready && cnt_reg == '0))
        else $error("block did not return to loading");

    a_span_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        span_reg != '0)
        else $error("doubling distance collapsed to zero");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the suffix array builder core.
`timescale 1ns / 100ps

module testbench
    import sab_pkg::*;
();

    localparam int STR_MAX   = 64;
    localparam int RAND_ITEMS = 430;
    localparam longint CYCLE_LIMIT = 6000000;

    typedef struct {
        logic [7:0] sym;
        logic       eot;
        bit         typed;     // expectation written in the row
        logic [5:0] start;
    } stim_row_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    sab_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    sab_out_t m_data;

    sab_out_t   sorted_starts_q[$];
    logic [7:0] text_q[$];
    int         send_idle_pct;
    int         recv_stall_pct;
    int         mismatches;
    longint     cycles;
    int         full_strings;

    suffix_array_builder_core #(.MAX_LEN(STR_MAX)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Sort all suffixes of the held string by prefix doubling and queue
    // their starts; the end sentinel ranks below every real rank.
    task automatic sort_suffixes();
        int n;
        int span;
        int rk[STR_MAX];
        int nxt[STR_MAX];
        int ord[STR_MAX];
        int keys[STR_MAX];
        int cur;
        int j;
        sab_out_t beat;
        n = text_q.size();
        for (int i = 0; i < n; i++) begin
            rk[i]  = int'(text_q[i]);
            ord[i] = i;
        end
        for (span = 1; span < n; span = span * 2) begin
            for (int i = 0; i < n; i++) begin
                keys[i] = (rk[i] << 9) | ((i + span < n) ? rk[i + span] + 1 : 0);
            end
            for (int i = 1; i < n; i++) begin
                cur = ord[i];
                j = i;
                while (j > 0 && keys[ord[j - 1]] > keys[cur]) begin
                    ord[j] = ord[j - 1];
                    j--;
                end
                ord[j] = cur;
            end
            for (int i = 0; i < n; i++) begin
                if (i > 0 && keys[ord[i - 1]] == keys[ord[i]]) begin
                    nxt[ord[i]] = nxt[ord[i - 1]];
                end else begin
                    nxt[ord[i]] = i;
                end
            end
            for (int i = 0; i < n; i++) rk[i] = nxt[i];
        end
        for (int i = 0; i < n; i++) begin
            beat.suffix_start = ord[i][5:0];
            beat.final_entry  = (i == n - 1);
            sorted_starts_q.push_back(beat);
        end
        text_q.delete();
    endtask

    // Drive one byte beat; hold it until taken, then update the prediction.
    task automatic send_byte(input logic [7:0] sym, input logic eot,
                             input bit typed, input logic [5:0] start);
        sab_out_t beat;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid            = 1'b1;
        s_data.symbol      = sym;
        s_data.end_of_text = eot;
        do @(posedge aclk); while (!s_ready);
        text_q.push_back(sym);
        if (eot || text_q.size() == STR_MAX) begin
            if (typed) begin
                beat.suffix_start = start;
                beat.final_entry  = 1'b1;
                sorted_starts_q.push_back(beat);
                text_q.delete();
            end else begin
                sort_suffixes();
            end
        end
        @(negedge aclk);
    endtask

    // Receiver: stall at the falling edge, check at the rising edge.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        sab_out_t want;
        mismatches = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (sorted_starts_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: start %0d final %0b",
                                 m_data.suffix_start, m_data.final_entry);
                end else begin
                    want = sorted_starts_q.pop_front();
                    if (m_data.suffix_start !== want.suffix_start ||
                        m_data.final_entry !== want.final_entry) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected start %0d final %0b, got %0d %0b",
                                     want.suffix_start, want.final_entry,
                                     m_data.suffix_start, m_data.final_entry);
                    end
                end
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    stim_row_t directed[] = '{
        '{8'h00, 1'b1, 1'b1, 6'd0},
        '{8'hFF, 1'b1, 1'b1, 6'd0},
        '{8'h41, 1'b1, 1'b1, 6'd0},
        '{8'h42, 1'b0, 1'b0, 6'd0},
        '{8'h41, 1'b1, 1'b0, 6'd0},
        '{8'h41, 1'b0, 1'b0, 6'd0},
        '{8'h41, 1'b1, 1'b0, 6'd0},
        '{8'h80, 1'b0, 1'b0, 6'd0},
        '{8'h7F, 1'b1, 1'b0, 6'd0},
        '{8'h41, 1'b0, 1'b0, 6'd0},
        '{8'h42, 1'b0, 1'b0, 6'd0},
        '{8'h41, 1'b0, 1'b0, 6'd0},
        '{8'h42, 1'b1, 1'b0, 6'd0},
        '{8'hFF, 1'b0, 1'b0, 6'd0},
        '{8'h00, 1'b0, 1'b0, 6'd0},
        '{8'hFF, 1'b0, 1'b0, 6'd0},
        '{8'h00, 1'b0, 1'b0, 6'd0},
        '{8'hFF, 1'b1, 1'b0, 6'd0}
    };

    initial begin
        int sent;
        int len;
        int mode;
        logic [7:0] sym;
        logic eot;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        full_strings   = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed[i])
            send_byte(directed[i].sym, directed[i].eot, directed[i].typed,
                      directed[i].start);

        sent = 0;
        while (sent < RAND_ITEMS) begin
            case (sent * 4 / RAND_ITEMS)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            // keep full-length strings rare: each one is costly to build
            if (full_strings < 3 && $urandom_range(14) == 0) begin
                len = STR_MAX;
                full_strings++;
            end else begin
                len = $urandom_range(12, 1);
            end
            mode = $urandom_range(2);
            for (int k = 0; k < len; k++) begin
                case (mode)
                    0:       sym = 8'($urandom_range(255));
                    1:       sym = 8'(8'h41 + $urandom_range(1));
                    default: sym = $urandom_range(1) ? 8'hFF : 8'h00;
                endcase
                // a full string may end on its own without the marker
                eot = (k == len - 1) ? ((len == STR_MAX) ? 1'($urandom_range(1)) : 1'b1)
                                     : 1'b0;
                send_byte(sym, eot, 1'b0, 6'd0);
            end
            sent += len;
        end
        s_valid = 1'b0;

        while (sorted_starts_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && sorted_starts_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/sab_pkg.sv
hw/rtl/suffix_array_builder_core.sv
dv/testbench.sv
